### hdl/tf256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threefish-256 encrypt package
// Types, constants and helper functions shared by the cipher core.
// ----------------------------------------------------------------------------
package tf256_pkg;

	localparam int WORD_W = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [WORD_W-1:0] KEY_PARITY = 64'h1BD1_1BDA_A9FC_1A22;

	localparam logic [REG_IDX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TWEAK0 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TWEAK1 = 3'd5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0] block_t;
	typedef logic [5:0] rot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SKEY,
		ST_INJECT,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef struct packed {
		rot_t r0;
		rot_t r1;
	} rot_pair_t;

	function automatic rot_pair_t rot_lookup(input logic [2:0] idx);
		rot_pair_t rp;
		case (idx)
			3'd0: rp = '{r0: 6'd14, r1: 6'd16};
			3'd1: rp = '{r0: 6'd52, r1: 6'd57};
			3'd2: rp = '{r0: 6'd23, r1: 6'd40};
			3'd3: rp = '{r0: 6'd5,  r1: 6'd37};
			3'd4: rp = '{r0: 6'd25, r1: 6'd33};
			3'd5: rp = '{r0: 6'd46, r1: 6'd12};
			3'd6: rp = '{r0: 6'd58, r1: 6'd22};
			3'd7: rp = '{r0: 6'd32, r1: 6'd32};
			default: rp = '{r0: 6'd0, r1: 6'd0};
		endcase
		return rp;
	endfunction

	function automatic word_t rotl64(input word_t x, input rot_t n);
		logic [2*WORD_W-1:0] d;
		d = {x, x} << n;
		return d[2*WORD_W-1:WORD_W];
	endfunction

endpackage

### hdl/threefish256_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threefish-256 encrypt
// Iterative Threefish-256 block encryption with APB key and tweak registers.
// ----------------------------------------------------------------------------
// One 256-bit plaintext block enters on the slave stream, the ciphertext
// leaves on the master stream. A single round unit (two 64-bit adders, two
// rotators) runs one MIX round per cycle between injections, and four further
// adders inject a subkey in a state of their own; the subkey is registered
// ahead of its injection from rotating key and tweak rings. Each item passes
// through load, subkey setup, ceil(NUM_ROUNDS/4) + 1 injections, NUM_ROUNDS
// rounds and unload to the output register before the next block is accepted.
// The output register holds a result while the next block is taken in.
// Key and tweak registers sit at byte addresses 0, 8, ..., 40 (key words
// 0..3, tweak words 0..1); they must be written only while idle, and the
// block itself does not enforce this.
module threefish256_encrypt #(
	parameter int NUM_ROUNDS = 72
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// plaintext
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // plain0, plain1, plain2, plain3
	// ciphertext
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata   // cipher0, cipher1, cipher2, cipher3
);

	localparam int RND_W = $clog2(NUM_ROUNDS + 1);
	localparam int NUM_SKEYS = (NUM_ROUNDS + 3) / 4 + 1;
	localparam int SIDX_W = $clog2(NUM_SKEYS + 1);
	localparam int W = tf256_pkg::WORD_W;

	tf256_pkg::state_t state_q, state_d;

	tf256_pkg::word_t key_q [4];
	tf256_pkg::word_t tweak_q [2];
	tf256_pkg::word_t ek_q [5];
	tf256_pkg::word_t et_q [3];
	tf256_pkg::block_t work_q;
	tf256_pkg::block_t skey_q;
	tf256_pkg::block_t out_q;
	logic [RND_W-1:0] rnd_q;
	logic [SIDX_W-1:0] sidx_q;
	logic out_valid_q;

	logic do_load, do_inject, do_round, do_unload;
	logic [tf256_pkg::REG_IDX_W-1:0] reg_idx;
	logic cfg_write;

	tf256_pkg::rot_pair_t rot;
	tf256_pkg::word_t y0, y1, y2, y3;
	tf256_pkg::block_t skey_d;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			for (int i = 0; i < 2; i++) tweak_q[i] <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				tf256_pkg::REG_KEY0:   key_q[0] <= pwdata;
				tf256_pkg::REG_KEY1:   key_q[1] <= pwdata;
				tf256_pkg::REG_KEY2:   key_q[2] <= pwdata;
				tf256_pkg::REG_KEY3:   key_q[3] <= pwdata;
				tf256_pkg::REG_TWEAK0: tweak_q[0] <= pwdata;
				tf256_pkg::REG_TWEAK1: tweak_q[1] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tf256_pkg::REG_KEY0:   prdata = key_q[0];
			tf256_pkg::REG_KEY1:   prdata = key_q[1];
			tf256_pkg::REG_KEY2:   prdata = key_q[2];
			tf256_pkg::REG_KEY3:   prdata = key_q[3];
			tf256_pkg::REG_TWEAK0: prdata = tweak_q[0];
			tf256_pkg::REG_TWEAK1: prdata = tweak_q[1];
			default:               prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tf256_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tf256_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = tf256_pkg::ST_SKEY;
			end
			tf256_pkg::ST_SKEY: begin
				state_d = tf256_pkg::ST_INJECT;
			end
			tf256_pkg::ST_INJECT: begin
				if (rnd_q == RND_W'(NUM_ROUNDS)) state_d = tf256_pkg::ST_OUT;
				else state_d = tf256_pkg::ST_ROUND;
			end
			tf256_pkg::ST_ROUND: begin
				if (rnd_q == RND_W'(NUM_ROUNDS - 1) || rnd_q[1:0] == 2'b11)
					state_d = tf256_pkg::ST_INJECT;
			end
			tf256_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) state_d = tf256_pkg::ST_IDLE;
			end
			default: state_d = tf256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		do_inject = 1'b0;
		do_round = 1'b0;
		do_unload = 1'b0;
		case (state_q)
			tf256_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			tf256_pkg::ST_SKEY:   ;
			tf256_pkg::ST_INJECT: do_inject = 1'b1;
			tf256_pkg::ST_ROUND:  do_round = 1'b1;
			tf256_pkg::ST_OUT:    do_unload = !out_valid_q || m_axis_tready;
			default:              ;
		endcase
	end

	assign do_load = s_axis_tvalid && s_axis_tready;

	// round unit
	assign rot = tf256_pkg::rot_lookup(rnd_q[2:0]);
	assign y0 = work_q[0] + work_q[1];
	assign y1 = tf256_pkg::rotl64(work_q[1], rot.r0) ^ y0;
	assign y2 = work_q[2] + work_q[3];
	assign y3 = tf256_pkg::rotl64(work_q[3], rot.r1) ^ y2;

	assign skey_d[0] = ek_q[0];
	assign skey_d[1] = ek_q[1] + et_q[0];
	assign skey_d[2] = ek_q[2] + et_q[1];
	assign skey_d[3] = ek_q[3] + {{(W-SIDX_W){1'b0}}, sidx_q};

	always_ff @(posedge clk) begin
		skey_q <= skey_d;
		if (do_load) begin
			work_q <= s_axis_tdata;
			for (int i = 0; i < 4; i++) ek_q[i] <= key_q[i];
			ek_q[4] <= tf256_pkg::KEY_PARITY ^ key_q[0] ^ key_q[1] ^ key_q[2] ^ key_q[3];
			et_q[0] <= tweak_q[0];
			et_q[1] <= tweak_q[1];
			et_q[2] <= tweak_q[0] ^ tweak_q[1];
		end else if (do_inject) begin
			for (int i = 0; i < 4; i++) work_q[i] <= work_q[i] + skey_q[i];
			for (int i = 0; i < 4; i++) ek_q[i] <= ek_q[i+1];
			ek_q[4] <= ek_q[0];
			et_q[0] <= et_q[1];
			et_q[1] <= et_q[2];
			et_q[2] <= et_q[0];
		end else if (do_round) begin
			work_q <= {y1, y2, y3, y0};
		end
		if (do_unload) out_q <= work_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			sidx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load || do_unload) begin
				rnd_q <= '0;
				sidx_q <= '0;
			end else begin
				if (do_round) rnd_q <= rnd_q + 1'b1;
				if (do_inject) sidx_q <= sidx_q + 1'b1;
			end
			if (do_unload) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tf256_pkg::ST_IDLE |-> rnd_q == '0 && sidx_q == '0)
		else $error("counters not cleared in idle");

	a_load_starts_skey: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == tf256_pkg::ST_SKEY)
		else $error("accepted block did not start subkey setup");

	a_inject_origin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tf256_pkg::ST_INJECT |->
			$past(state_q) == tf256_pkg::ST_SKEY || $past(state_q) == tf256_pkg::ST_ROUND)
		else $error("injection without a prepared subkey");

	a_final_subkey: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tf256_pkg::ST_INJECT && rnd_q == RND_W'(NUM_ROUNDS) |->
			sidx_q == SIDX_W'((NUM_ROUNDS + 3) / 4))
		else $error("final injection uses wrong subkey index");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threefish-256 encrypt testbench
// Streams plaintext blocks into the cipher under a range of key and tweak
// settings. Each ciphertext transfer is checked word by word against a local
// Threefish-256 computation. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ROUNDS        = 72;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;

	localparam logic [tf256_pkg::REG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [tf256_pkg::REG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	localparam logic [0:7][5:0] ROT_EVEN = {6'd14, 6'd52, 6'd23, 6'd5, 6'd25, 6'd46, 6'd58, 6'd32};
	localparam logic [0:7][5:0] ROT_ODD  = {6'd16, 6'd57, 6'd40, 6'd37, 6'd33, 6'd12, 6'd22, 6'd32};

	localparam tf256_pkg::word_t ONES = '1;
	localparam tf256_pkg::word_t FIVES = 64'h5555_5555_5555_5555;
	localparam tf256_pkg::word_t TENS  = 64'hAAAA_AAAA_AAAA_AAAA;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [5:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata = '0;  // plain0, plain1, plain2, plain3
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [255:0] m_axis_tdata;       // cipher0, cipher1, cipher2, cipher3

	tf256_pkg::word_t  key_reg [4];
	tf256_pkg::word_t  tweak_reg [2];
	tf256_pkg::block_t plain_q [$];
	tf256_pkg::block_t cipher_q [$];
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     mismatches = 0;
	int     cycles = 0;

	threefish256_encrypt #(
		.NUM_ROUNDS(ROUNDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic tf256_pkg::block_t encrypt_block(input tf256_pkg::block_t plain);
		tf256_pkg::word_t  ks [5];
		tf256_pkg::word_t  ts [3];
		tf256_pkg::block_t w;
		tf256_pkg::word_t  t;
		int     i;
		int     d;
		int     s;
		int     n;
		ks[4] = tf256_pkg::KEY_PARITY;
		for (i = 0; i < 4; i++) begin
			ks[i] = key_reg[i];
			ks[4] ^= key_reg[i];
		end
		ts[0] = tweak_reg[0];
		ts[1] = tweak_reg[1];
		ts[2] = ts[0] ^ ts[1];
		w = plain;
		s = 0;
		for (d = 0; d <= ROUNDS; d++) begin
			if (d % 4 == 0 || d == ROUNDS) begin
				w[0] += ks[s % 5];
				w[1] += ks[(s + 1) % 5] + ts[s % 3];
				w[2] += ks[(s + 2) % 5] + ts[(s + 1) % 3];
				w[3] += ks[(s + 3) % 5] + tf256_pkg::word_t'(s);
				s++;
			end
			if (d < ROUNDS) begin
				n = ROT_EVEN[d % 8];
				w[0] += w[1];
				w[1] = ((w[1] << n) | (w[1] >> (tf256_pkg::WORD_W - n))) ^ w[0];
				n = ROT_ODD[d % 8];
				w[2] += w[3];
				w[3] = ((w[3] << n) | (w[3] >> (tf256_pkg::WORD_W - n))) ^ w[2];
				t = w[1];
				w[1] = w[3];
				w[3] = t;
			end
		end
		return w;
	endfunction

	function automatic tf256_pkg::word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic tf256_pkg::block_t rand_block();
		tf256_pkg::block_t b;
		int     i;
		for (i = 0; i < 4; i++)
			b[i] = rand_word();
		return b;
	endfunction

	task automatic note_fault(input string what, input tf256_pkg::word_t want,
			input tf256_pkg::word_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch: %s expected %h got %h", what, want, got);
	endtask

	task automatic write_reg(input logic [tf256_pkg::REG_IDX_W-1:0] idx,
			input tf256_pkg::word_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < tf256_pkg::REG_TWEAK0)
			key_reg[idx] = value;
		else if (idx <= tf256_pkg::REG_TWEAK1)
			tweak_reg[idx - tf256_pkg::REG_TWEAK0] = value;
	endtask

	task automatic set_keys(input tf256_pkg::word_t k0, input tf256_pkg::word_t k1,
			input tf256_pkg::word_t k2, input tf256_pkg::word_t k3,
			input tf256_pkg::word_t t0, input tf256_pkg::word_t t1);
		write_reg(tf256_pkg::REG_KEY0, k0);
		write_reg(tf256_pkg::REG_KEY1, k1);
		write_reg(tf256_pkg::REG_KEY2, k2);
		write_reg(tf256_pkg::REG_KEY3, k3);
		write_reg(tf256_pkg::REG_TWEAK0, t0);
		write_reg(tf256_pkg::REG_TWEAK1, t1);
	endtask

	// hold until every block is through, then let the core settle
	task automatic wait_quiet();
		do @(negedge clk); while (plain_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int count, input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			plain_q.push_back(rand_block());
		wait_quiet();
	endtask

	always @(posedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata <= plain_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_cipher
		tf256_pkg::block_t want;
		tf256_pkg::block_t got;
		int     f;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (cipher_q.size() == 0) begin
				note_fault("unexpected transfer, cipher0", '0, got[0]);
			end else begin
				want = cipher_q.pop_front();
				for (f = 0; f < 4; f++)
					if (got[f] !== want[f])
						note_fault($sformatf("cipher%0d", f), want[f], got[f]);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			cipher_q.push_back(encrypt_block(s_axis_tdata));
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < 4; i++)
			key_reg[i] = '0;
		for (i = 0; i < 2; i++)
			tweak_reg[i] = '0;
		send_idle_pct = 11;
		recv_idle_pct = 64;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// zero key and tweak from reset
		@(negedge clk);
		plain_q.push_back('0);
		plain_q.push_back({ONES, ONES, ONES, ONES});
		plain_q.push_back({FIVES, FIVES, FIVES, FIVES});
		plain_q.push_back({TENS, TENS, TENS, TENS});
		wait_quiet();

		// all-ones key and tweak; writes past the last register must be dropped
		set_keys(ONES, ONES, ONES, ONES, ONES, ONES);
		write_reg(REG_SPARE6, {$urandom, $urandom});
		write_reg(REG_SPARE7, '0);
		@(negedge clk);
		plain_q.push_back('0);
		plain_q.push_back({ONES, ONES, ONES, ONES});
		plain_q.push_back({64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h1});
		wait_quiet();

		set_keys(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0, ONES, ONES, '0);
		@(negedge clk);
		plain_q.push_back({TENS, FIVES, TENS, FIVES});
		plain_q.push_back(rand_block());
		plain_q.push_back(rand_block());
		wait_quiet();

		set_keys(rand_word(), rand_word(), rand_word(), rand_word(), '0, ONES);
		@(negedge clk);
		plain_q.push_back({FIVES, TENS, FIVES, TENS});
		plain_q.push_back(rand_block());
		plain_q.push_back(rand_block());
		wait_quiet();

		for (i = 0; i < 6; i++) begin
			set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, rand_word(), rand_word());
			case (i / 2)
				0: run_random(125, 11, 64);
				1: run_random(125, 64, 11);
				default: run_random(125, 0, 0);
			endcase
		end

		if (mismatches == 0 && cipher_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
